[src/psc_pkg.sv]
// shared widths and constants for the palindromic substring counter
package psc_pkg;

  // raw character byte
  localparam int unsigned CHAR_W = 8;

  // result count width and its saturation value
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

[src/palindromic_substring_counter_core.sv]
// palindromic substring counter: character store, palindrome column and scan sequencer
//
// Takes a string one character per input word, with last marking the final
// character, and returns one result word per string: the number of palindromic
// substrings (count, saturating at 65535) and too_long, set when the string had
// more than MAX_LEN characters (extra characters are dropped). A kept character
// at position j (from 0) is compared against every stored character by a single
// byte comparator reading one entry per cycle from the character memory, so the
// block takes no new character until that scan ends (the memory read is
// registered). A dropped character is taken without a scan. After the final character
// the result word is held until taken; input is not accepted meanwhile, and the
// block starts the next string empty. No clearing pass is needed after reset.
module palindromic_substring_counter_core
  import psc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  ch,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] count,
  output logic               too_long
);

  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]         state;
  logic [CHAR_W-1:0]  cur_ch;
  logic               cur_last;
  logic [IDX_W-1:0]   cur_pos;
  logic [IDX_W-1:0]   rd_idx;
  logic               issuing;
  logic               dv;
  logic [IDX_W-1:0]   di;
  logic [LEN_W-1:0]   len_seen;
  logic [COUNT_W-1:0] run_count;
  logic               ovf;

  // character store and palindrome column
  logic [CHAR_W-1:0]  char_mem [MAX_LEN];
  logic               pal_mem  [MAX_LEN];
  logic [CHAR_W-1:0]  char_q;
  logic               pal_q;

  logic               in_fire;
  logic               out_fire;
  logic               full;
  logic [IDX_W-1:0]   span;
  logic               hit;
  logic [IDX_W-1:0]   pal_rd_idx;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign full      = (len_seen >= LEN_W'(MAX_LEN));
  assign count     = run_count;
  assign too_long  = ovf;

  // entry i starts a palindrome ending at the new character when chars match and the inner span is empty or was one
  assign span       = cur_pos - di;
  assign hit        = (char_q == cur_ch) && ((span <= IDX_W'(1)) || pal_q);
  assign pal_rd_idx = rd_idx + IDX_W'(1);

  // character memory: write on accept, registered read at scan index
  always_ff @(posedge clk) begin
    if (in_fire && !full) begin
      char_mem[len_seen[IDX_W-1:0]] <= ch;
    end
    char_q <= char_mem[rd_idx];
  end

  // palindrome column memory: read the old bit i+1, write the new bit i
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && dv) begin
      pal_mem[di] <= hit;
    end
    pal_q <= pal_mem[pal_rd_idx];
  end

  // scan sequencer and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issuing   <= 1'b0;
      dv        <= 1'b0;
      len_seen  <= '0;
      run_count <= '0;
      ovf       <= 1'b0;
      rd_idx    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (full) begin
              ovf <= 1'b1;
              if (last) begin
                state <= ST_OUT;
              end
            end else begin
              cur_ch   <= ch;
              cur_last <= last;
              cur_pos  <= len_seen[IDX_W-1:0];
              rd_idx   <= '0;
              issuing  <= 1'b1;
              dv       <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // read issue
          if (issuing) begin
            if (rd_idx == cur_pos) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          dv <= issuing;
          di <= rd_idx;
          // compare and count
          if (dv) begin
            if (hit && run_count != COUNT_MAX) begin
              run_count <= run_count + COUNT_W'(1);
            end
            if (di == cur_pos) begin
              len_seen <= LEN_W'(cur_pos) + LEN_W'(1);
              state    <= cur_last ? ST_OUT : ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            len_seen  <= '0;
            run_count <= '0;
            ovf       <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // no input taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // a delivered result leaves the block empty
  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> (len_seen == '0) && (run_count == '0) && !ovf)
    else $error("state not cleared after result");

  // a scan never starts on a full store
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (len_seen < LEN_W'(MAX_LEN)))
    else $error("scan with full character store");

  // compared entries never pass the new character
  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && dv |-> (di <= cur_pos))
    else $error("scan index past current position");
`endif

endmodule
